### hw/rtl/usgt_pkg.sv
// Shared constants, codes and state type for the union/split group tracker.
`timescale 1ns / 1ps

package usgt_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int NODE_COUNT  = 2 * MAX_ITEMS - 1;
    localparam int INNER_COUNT = MAX_ITEMS - 1;

    localparam int IDX_W  = 6;
    localparam int NODE_W = 7;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] CNT_RESET   = 7'd64;
    localparam logic [CNT_W-1:0] FREE_RESET  = 7'd63;
    localparam logic [NODE_W-1:0] NODE_LIMIT = 7'd127;
    localparam logic [NODE_W-1:0] INNER_BASE = 7'd64;

    localparam logic [1:0] FUNC_MERGE = 2'd0;
    localparam logic [1:0] FUNC_SPLIT = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NOOP    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_POP,
        ST_LINK_B,
        ST_SPLIT_RD
    } t_state;

endpackage

### hw/rtl/union_split_group_tracker.sv
// Union/split group tracker: merge-tree sequencer over parent, child and free-stack memories.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive start with func, first_index and second_index while
//   busy is low; the item is taken at that clock edge.
//   Result channel: o_result_strobe is high for one cycle with o_same_group and
//   o_status; the receiver cannot stall, so every result must be captured then.
//   Config: i_cfg_we with i_cfg_wdata writes company_count; write only when idle.
// Sequence (accept edge to strobe cycle):
//   invalid index, unknown func, split of a lone item: answered from the command, no memory access.
//   query: walk from the first item to its root, then from the second, one parent
//          memory read per link (data used the next cycle).
//   merge: query walk, then free stack read and two parent memory writes.
//   split: walk to the root, child memory read, then links cleared and node pushed.
//   One item is in work at a time, and busy drops in the strobe cycle.
// Reset: all nodes unlinked, free stack full with internal nodes 64..126 (slots
//   0..62), company_count = 64. Valid bits live in flops, so no clearing pass is needed.
module union_split_group_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic [usgt_pkg::IDX_W-1:0]   i_first_index,
    input  logic [usgt_pkg::IDX_W-1:0]   i_second_index,
    input  logic                         i_cfg_we,
    input  logic [usgt_pkg::CNT_W-1:0]   i_cfg_wdata,
    output logic                         o_result_strobe,
    output logic                         o_same_group,
    output logic [1:0]                   o_status
);
    import usgt_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_company_count;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [1:0]        r_func, n_func;
    logic [IDX_W-1:0]  r_b, n_b;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic              r_pend, n_pend;
    logic [NODE_W-1:0] r_ra, n_ra;
    logic [NODE_W-1:0] r_rb, n_rb;
    logic [NODE_W-1:0] r_node, n_node;
    logic              r_strobe, n_strobe;
    logic              r_same, n_same;
    logic [1:0]        r_status, n_status;

    logic [NODE_W-1:0]   parent_mem [NODE_COUNT];
    logic [2*NODE_W-1:0] child_mem  [INNER_COUNT];
    logic [SLOT_W-1:0]   stack_mem  [INNER_COUNT];

    logic [NODE_COUNT-1:0]  r_pvld;
    logic [INNER_COUNT-1:0] r_svld;

    logic [NODE_W-1:0]   r_par_rd;
    logic [2*NODE_W-1:0] r_child_rd;
    logic [SLOT_W-1:0]   r_stk_rd;
    logic [SLOT_W-1:0]   r_stk_addr;
    logic                r_stk_hit;

    logic                par_re, par_we;
    logic [NODE_W-1:0]   par_raddr, par_waddr, par_wdata;
    logic                child_re, child_we;
    logic [SLOT_W-1:0]   child_raddr, child_waddr;
    logic [2*NODE_W-1:0] child_wdata;
    logic                stk_re, stk_we;
    logic [SLOT_W-1:0]   stk_raddr, stk_waddr, stk_wdata;
    logic                pv_set, pv_clr;
    logic [NODE_W-1:0]   pv_set_idx, pv_clr_idx0, pv_clr_idx1;

    logic              a_ok, b_ok, idle_fast;
    logic              a_linked;
    logic [NODE_W-1:0] w_cur;
    logic              w_cur_vld;
    logic              split_ok, merge_ok;
    logic [SLOT_W-1:0] pop_slot;

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_same_group    = r_same;
    assign o_status        = r_status;

    assign a_ok     = {1'b0, i_first_index} < r_company_count;
    assign b_ok     = {1'b0, i_second_index} < r_company_count;
    assign a_linked = r_pvld[{1'b0, i_first_index}];

    always_comb begin
        unique case (i_func)
            FUNC_MERGE, FUNC_QUERY: idle_fast = !(a_ok && b_ok);
            FUNC_SPLIT:             idle_fast = !a_ok || !a_linked;
            default:                idle_fast = 1'b1;
        endcase
    end

    assign w_cur     = r_pend ? r_par_rd : r_cur;
    assign w_cur_vld = (w_cur < NODE_LIMIT) ? r_pvld[w_cur] : 1'b0;
    assign split_ok  = (w_cur >= INNER_BASE) && (w_cur < NODE_LIMIT)
                     && (r_free_count < FREE_RESET);
    assign merge_ok  = (w_cur != r_ra) && (r_free_count != '0);
    assign pop_slot  = r_stk_hit ? r_stk_rd : r_stk_addr;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && !idle_fast) begin
                    n_state = ST_WALK_A;
                end
            end
            ST_WALK_A: begin
                if (!w_cur_vld) begin
                    if (r_func == FUNC_SPLIT) begin
                        n_state = split_ok ? ST_SPLIT_RD : ST_IDLE;
                    end else begin
                        n_state = ST_WALK_B;
                    end
                end
            end
            ST_WALK_B: begin
                if (!w_cur_vld) begin
                    n_state = (r_func == FUNC_MERGE && merge_ok) ? ST_POP : ST_IDLE;
                end
            end
            ST_POP:      n_state = ST_LINK_B;
            ST_LINK_B:   n_state = ST_IDLE;
            ST_SPLIT_RD: n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_free_count = r_free_count;
        n_func       = r_func;
        n_b          = r_b;
        n_cur        = r_cur;
        n_pend       = r_pend;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_node       = r_node;
        n_strobe     = 1'b0;
        n_same       = 1'b0;
        n_status     = STAT_DONE;
        par_re       = 1'b0;
        par_raddr    = w_cur;
        par_we       = 1'b0;
        par_waddr    = r_ra;
        par_wdata    = r_node;
        child_re     = 1'b0;
        child_raddr  = w_cur[SLOT_W-1:0];
        child_we     = 1'b0;
        child_waddr  = pop_slot;
        child_wdata  = {r_ra, r_rb};
        stk_re       = 1'b0;
        stk_raddr    = SLOT_W'(r_free_count - 1'b1);
        stk_we       = 1'b0;
        stk_waddr    = r_free_count[SLOT_W-1:0];
        stk_wdata    = r_ra[SLOT_W-1:0];
        pv_set       = 1'b0;
        pv_set_idx   = r_ra;
        pv_clr       = 1'b0;
        pv_clr_idx0  = r_child_rd[2*NODE_W-1:NODE_W];
        pv_clr_idx1  = r_child_rd[NODE_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_b    = i_second_index;
                    n_cur  = {1'b0, i_first_index};
                    n_pend = 1'b0;
                    if (idle_fast) begin
                        n_strobe = 1'b1;
                        if ((i_func == FUNC_MERGE || i_func == FUNC_QUERY
                             || i_func == FUNC_SPLIT) && !a_ok) begin
                            n_status = STAT_INVALID;
                        end else if ((i_func == FUNC_MERGE || i_func == FUNC_QUERY)
                                     && !b_ok) begin
                            n_status = STAT_INVALID;
                        end else begin
                            n_status = STAT_NOOP;
                        end
                    end
                end
            end
            ST_WALK_A: begin
                if (w_cur_vld) begin
                    par_re = 1'b1;
                    n_cur  = w_cur;
                    n_pend = 1'b1;
                end else begin
                    n_ra = w_cur;
                    if (r_func == FUNC_SPLIT) begin
                        if (split_ok) begin
                            child_re = 1'b1;
                        end else begin
                            n_strobe = 1'b1;
                            n_status = STAT_NOOP;
                        end
                    end else begin
                        n_cur  = {1'b0, r_b};
                        n_pend = 1'b0;
                    end
                end
            end
            ST_WALK_B: begin
                if (w_cur_vld) begin
                    par_re = 1'b1;
                    n_cur  = w_cur;
                    n_pend = 1'b1;
                end else begin
                    n_rb = w_cur;
                    if (r_func == FUNC_MERGE) begin
                        if (merge_ok) begin
                            stk_re = 1'b1;
                        end else begin
                            n_strobe = 1'b1;
                            n_status = STAT_NOOP;
                        end
                    end else begin
                        n_strobe = 1'b1;
                        n_same   = (w_cur == r_ra);
                    end
                end
            end
            ST_POP: begin
                child_we     = 1'b1;
                par_we       = 1'b1;
                par_waddr    = r_ra;
                par_wdata    = {1'b1, pop_slot};
                pv_set       = 1'b1;
                pv_set_idx   = r_ra;
                n_node       = {1'b1, pop_slot};
                n_free_count = r_free_count - 1'b1;
            end
            ST_LINK_B: begin
                par_we     = 1'b1;
                par_waddr  = r_rb;
                par_wdata  = r_node;
                pv_set     = 1'b1;
                pv_set_idx = r_rb;
                n_strobe   = 1'b1;
            end
            ST_SPLIT_RD: begin
                pv_clr       = 1'b1;
                stk_we       = 1'b1;
                n_free_count = r_free_count + 1'b1;
                n_strobe     = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_company_count <= CNT_RESET;
            r_free_count    <= FREE_RESET;
            r_pend          <= 1'b0;
            r_strobe        <= 1'b0;
            r_pvld          <= '0;
            r_svld          <= '0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_pend       <= n_pend;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_company_count <= i_cfg_wdata;
            end
            if (pv_clr) begin
                r_pvld[pv_clr_idx0] <= 1'b0;
                r_pvld[pv_clr_idx1] <= 1'b0;
            end
            if (pv_set) begin
                r_pvld[pv_set_idx] <= 1'b1;
            end
            if (stk_we) begin
                r_svld[stk_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_node   <= n_node;
        r_same   <= n_same;
        r_status <= n_status;
    end

    // parent link memory
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            parent_mem[par_waddr] <= par_wdata;
        end
        if (par_re) begin
            r_par_rd <= parent_mem[par_raddr];
        end
    end

    // child pair memory
    always_ff @(posedge i_clk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (child_re) begin
            r_child_rd <= child_mem[child_raddr];
        end
    end

    // free node stack; an entry never written holds its own index
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_rd   <= stack_mem[stk_raddr];
            r_stk_addr <= stk_raddr;
            r_stk_hit  <= r_svld[stk_raddr];
        end
    end

endmodule

### test/usgt_group_checker.sv
// Checker for the group tracker: predicts each item's answer and compares results.
`timescale 1ns / 1ps

module usgt_group_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_func,
    input  logic [usgt_pkg::IDX_W-1:0]  i_first_index,
    input  logic [usgt_pkg::IDX_W-1:0]  i_second_index,
    input  logic                        i_cfg_we,
    input  logic [usgt_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                        i_result_strobe,
    input  logic                        i_same_group,
    input  logic [1:0]                  i_status,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_deepest
);
    import usgt_pkg::*;

    typedef struct packed {
        logic       same;
        logic [1:0] status;
    } t_answer;

    t_answer answer_q[$];
    t_answer want;

    logic [CNT_W-1:0]  item_count;
    logic              linked   [NODE_COUNT];
    logic [NODE_W-1:0] up_node  [NODE_COUNT];
    logic [NODE_W-1:0] kids     [INNER_COUNT][2];
    logic [SLOT_W-1:0] spare_slots [INNER_COUNT];
    int                spare_count;
    int                error_cnt = 0;
    int                result_cnt = 0;
    int                deepest_walk = 0;

    function automatic logic [NODE_W-1:0] walk_up(input logic [NODE_W-1:0] node);
        int hops;
        hops = 0;
        while (node < NODE_LIMIT && linked[node] && hops < 2 * MAX_ITEMS) begin
            node = up_node[node];
            hops++;
        end
        if (hops > deepest_walk)
            deepest_walk = hops;
        return node;
    endfunction

    function automatic t_answer predict_item(input logic [1:0] f,
                                             input logic [IDX_W-1:0] a,
                                             input logic [IDX_W-1:0] b);
        t_answer           ans;
        int                lim;
        int                slot;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        logic [NODE_W-1:0] node;
        ans.same   = 1'b0;
        ans.status = STAT_DONE;
        lim = (item_count < MAX_ITEMS) ? int'(item_count) : MAX_ITEMS;
        case (f)
            FUNC_MERGE: begin
                if (int'(a) >= lim || int'(b) >= lim) begin
                    ans.status = STAT_INVALID;
                end else begin
                    ra = walk_up(NODE_W'(a));
                    rb = walk_up(NODE_W'(b));
                    if (ra == rb || spare_count == 0) begin
                        ans.status = STAT_NOOP;
                    end else begin
                        slot = spare_slots[(spare_count - 1) % INNER_COUNT] % INNER_COUNT;
                        node = NODE_W'(int'(INNER_BASE) + slot);
                        spare_count--;
                        kids[slot][0] = ra;
                        kids[slot][1] = rb;
                        linked[ra]  = 1'b1;
                        up_node[ra] = node;
                        linked[rb]  = 1'b1;
                        up_node[rb] = node;
                    end
                end
            end
            FUNC_SPLIT: begin
                if (int'(a) >= lim) begin
                    ans.status = STAT_INVALID;
                end else if (!linked[a]) begin
                    ans.status = STAT_NOOP;
                end else begin
                    ra = walk_up(NODE_W'(a));
                    if (ra >= INNER_BASE && ra < NODE_LIMIT && spare_count < INNER_COUNT) begin
                        slot = int'(ra) - int'(INNER_BASE);
                        rb = kids[slot][0];
                        linked[rb]  = 1'b0;
                        up_node[rb] = '0;
                        rb = kids[slot][1];
                        linked[rb]  = 1'b0;
                        up_node[rb] = '0;
                        spare_slots[spare_count] = SLOT_W'(slot);
                        spare_count++;
                    end else begin
                        ans.status = STAT_NOOP;
                    end
                end
            end
            FUNC_QUERY: begin
                if (int'(a) >= lim || int'(b) >= lim)
                    ans.status = STAT_INVALID;
                else
                    ans.same = (walk_up(NODE_W'(a)) == walk_up(NODE_W'(b)));
            end
            default: ans.status = STAT_NOOP;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_count = CNT_RESET;
            for (int k = 0; k < NODE_COUNT; k++) begin
                linked[k]  = 1'b0;
                up_node[k] = '0;
            end
            for (int k = 0; k < INNER_COUNT; k++)
                spare_slots[k] = SLOT_W'(k);
            spare_count = INNER_COUNT;
            answer_q.delete();
        end else begin
            // result of the previous item first: a new item may be taken on the same edge
            if (i_result_strobe) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: result with no item waiting: same_group %0b status %0d",
                             $time, i_same_group, i_status);
                    error_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    result_cnt++;
                    if (i_same_group !== want.same) begin
                        $display("%0t: same_group expected %0b, got %0b",
                                 $time, want.same, i_same_group);
                        error_cnt++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_status);
                        error_cnt++;
                    end
                end
            end
            if (i_cfg_we)
                item_count = i_cfg_wdata;
            if (i_start && !i_busy)
                answer_q.push_back(predict_item(i_func, i_first_index, i_second_index));
        end
        o_pending <= answer_q.size();
        o_errors  <= error_cnt;
        o_results <= result_cnt;
        o_deepest <= deepest_walk;
    end

endmodule

### test/tb_union_split_group_tracker.sv
// Testbench top for the group tracker: reset, count settings, item stimulus and verdict.
`timescale 1ns / 1ps

module tb_union_split_group_tracker;

    import usgt_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BATCH = 42;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_func = FUNC_MERGE;
    logic [IDX_W-1:0]  i_first_index = '0;
    logic [IDX_W-1:0]  i_second_index = '0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic              o_result_strobe;
    logic              o_same_group;
    logic [1:0]        o_status;

    int errors;
    int pending;
    int results;
    int deepest;
    int cycles = 0;
    int items_sent = 0;
    int settings_run = 0;
    int burst_left = 0;
    logic [CNT_W-1:0] cur_count = CNT_RESET;
    logic [CNT_W-1:0] count_plan [12];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    union_split_group_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_first_index   (i_first_index),
        .i_second_index  (i_second_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_same_group    (o_same_group),
        .o_status        (o_status)
    );

    usgt_group_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_first_index   (i_first_index),
        .i_second_index  (i_second_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_result_strobe (o_result_strobe),
        .i_same_group    (o_same_group),
        .i_status        (o_status),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_results       (results),
        .o_deepest       (deepest)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("union_split_group_tracker regression: fail");
            $finish;
        end
    end

    // start stays high across a burst; a gap drops it only after the accept edge
    task automatic send_item(input logic [1:0] f, input logic [IDX_W-1:0] a,
                             input logic [IDX_W-1:0] b);
        int gap;
        start          <= 1'b1;
        i_func         <= f;
        i_first_index  <= a;
        i_second_index <= b;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle;
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_count = value;
        settings_run++;
    endtask

    function automatic int active_items();
        return (cur_count < MAX_ITEMS) ? int'(cur_count) : MAX_ITEMS;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int lim;
        lim = active_items();
        if (lim == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, MAX_ITEMS - 1));
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // each merge puts the old root one level deeper: from unlinked items, item 0 ends n-1 links down
    task automatic build_chain(input int n);
        for (int k = 0; k + 1 < n; k++)
            send_item(FUNC_MERGE, IDX_W'(k), IDX_W'(k + 1));
    endtask

    task automatic random_items(input int n);
        int r;
        logic [1:0] f;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            f = (r < 45) ? FUNC_MERGE : (r < 63) ? FUNC_SPLIT
              : (r < 95) ? FUNC_QUERY : FUNC_UNKNOWN;
            send_item(f, pick_index(), pick_index());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full count
        send_item(FUNC_QUERY,   6'd0,  6'd63);
        send_item(FUNC_MERGE,   6'd0,  6'd63);
        send_item(FUNC_QUERY,   6'd63, 6'd0);
        send_item(FUNC_MERGE,   6'd63, 6'd0);
        send_item(FUNC_SPLIT,   6'd5,  6'd63);
        send_item(FUNC_MERGE,   6'd5,  6'd6);
        send_item(FUNC_MERGE,   6'd0,  6'd5);
        send_item(FUNC_QUERY,   6'd6,  6'd63);
        send_item(FUNC_SPLIT,   6'd6,  6'd0);
        send_item(FUNC_QUERY,   6'd0,  6'd6);
        send_item(FUNC_SPLIT,   6'd63, 6'd63);
        send_item(FUNC_SPLIT,   6'd63, 6'd0);
        send_item(FUNC_UNKNOWN, 6'd63, 6'd63);
        send_item(FUNC_QUERY,   6'd0,  6'd0);

        // lowered count: indexes past it are rejected as invalid, older links remain
        write_count(7'd4);
        send_item(FUNC_MERGE,   6'd3,  6'd4);
        send_item(FUNC_MERGE,   6'd4,  6'd3);
        send_item(FUNC_SPLIT,   6'd4,  6'd0);
        send_item(FUNC_QUERY,   6'd63, 6'd0);
        send_item(FUNC_SPLIT,   6'd3,  6'd63);
        send_item(FUNC_MERGE,   6'd0,  6'd3);
        send_item(FUNC_QUERY,   6'd3,  6'd0);

        write_count(7'd0);
        send_item(FUNC_MERGE,   6'd0,  6'd0);
        send_item(FUNC_QUERY,   6'd0,  6'd0);

        write_count(7'd127);
        send_item(FUNC_MERGE,   6'd63, 6'd3);
        send_item(FUNC_QUERY,   6'd0,  6'd63);

        count_plan = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd33, 7'd0,
                       7'd64, 7'd8, 7'd100, 7'd16, 7'd64, 7'd64};
        count_plan[4] = CNT_W'($urandom_range(1, 64));
        count_plan[9] = CNT_W'($urandom_range(1, 64));
        foreach (count_plan[p]) begin
            write_count(count_plan[p]);
            if (active_items() >= 32 && $urandom_range(0, 2) != 0)
                build_chain(active_items());
            random_items(RANDOM_BATCH);
        end

        settle();
        repeat (2 * MAX_ITEMS + 10) @(posedge i_clk);

        $display("Covered %0d items across %0d item-count settings, %0d results checked.",
                 items_sent, settings_run + 1, results);
        $display("Longest root walk reached: %0d links.", deepest);
        if (errors == 0)
            $display("union_split_group_tracker regression: pass");
        else
            $display("union_split_group_tracker regression: fail");
        $finish;
    end

endmodule
